### rtl/csr_el_pkg.sv
// ----------------------------------------------------------------------------
// csr_el_pkg
// Shared types and codes for the CSR sparse matrix element lookup block.
// ----------------------------------------------------------------------------
package csr_el_pkg;

  localparam int unsigned CFG_DW = 9;

  localparam logic [0:0] CFG_ROW_COUNT    = 1'b0;
  localparam logic [0:0] CFG_COLUMN_COUNT = 1'b1;

  typedef enum logic [1:0] {
    REQ_WR_START = 2'd0,
    REQ_WR_ENTRY = 2'd1,
    REQ_LOOKUP   = 2'd2
  } req_e;

  // store write request, issued on an accepted load beat
  typedef struct packed {
    logic               we_row;
    logic               we_ent;
    logic [11:0]        slot;
    logic [12:0]        ptr;
    logic [7:0]         col;
    logic signed [31:0] val;
  } wr_t;

  typedef struct packed {
    logic [8:0]  row_addr;
    logic [12:0] ent_addr;
  } rd_t;

  typedef struct packed {
    logic [12:0]        row_start;
    logic [7:0]         ent_col;
    logic signed [31:0] ent_val;
  } rdata_t;

endpackage

### rtl/csr_el_if.sv
// ----------------------------------------------------------------------------
// csr_el_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface csr_el_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [11:0]        slot;
  logic [12:0]        pointer_value;
  logic [7:0]         entry_column;
  logic signed [31:0] entry_value;
  logic [7:0]         query_row;
  logic [7:0]         query_col;

  modport source (
    output valid, req_type, slot, pointer_value, entry_column, entry_value,
           query_row, query_col,
    input  ready
  );
  modport sink (
    input  valid, req_type, slot, pointer_value, entry_column, entry_value,
           query_row, query_col,
    output ready
  );
endinterface

interface csr_el_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element_value;
  logic               hit;

  modport source (
    output valid, element_value, hit,
    input  ready
  );
  modport sink (
    input  valid, element_value, hit,
    output ready
  );
endinterface

### rtl/csr_el_mem.sv
// ----------------------------------------------------------------------------
// csr_el_mem
// Row-start store and the parallel entry column/value stores, each with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module csr_el_mem #(
  parameter int unsigned MAX_ROWS     = 256,
  parameter int unsigned MAX_NONZEROS = 4096
) (
  input  logic              clk_i,
  input  csr_el_pkg::wr_t   wr_i,
  input  csr_el_pkg::rd_t   rd_i,
  output csr_el_pkg::rdata_t rd_data_o
);
  import csr_el_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam int unsigned NW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;

  logic [12:0]        row_mem [MAX_ROWS + 1];
  logic [7:0]         col_mem [MAX_NONZEROS];
  logic signed [31:0] val_mem [MAX_NONZEROS];

  logic [31:0] slot_ext;
  logic [31:0] row_raddr_ext;
  logic [31:0] ent_raddr_ext;

  assign slot_ext      = 32'(wr_i.slot);
  assign row_raddr_ext = 32'(rd_i.row_addr);
  assign ent_raddr_ext = 32'(rd_i.ent_addr);

  always_ff @(posedge clk_i) begin
    if (wr_i.we_row) begin
      row_mem[slot_ext[RW-1:0]] <= wr_i.ptr;
    end
    if (wr_i.we_ent) begin
      col_mem[slot_ext[NW-1:0]] <= wr_i.col;
      val_mem[slot_ext[NW-1:0]] <= wr_i.val;
    end
    rd_data_o.row_start <= row_mem[row_raddr_ext[RW-1:0]];
    rd_data_o.ent_col   <= col_mem[ent_raddr_ext[NW-1:0]];
    rd_data_o.ent_val   <= val_mem[ent_raddr_ext[NW-1:0]];
  end

endmodule

### rtl/csr_el_seq.sv
// ----------------------------------------------------------------------------
// csr_el_seq
// Request sequencer: issues store writes, fetches the row span and scans it
// one entry per cycle through a single column comparator.
// ----------------------------------------------------------------------------
module csr_el_seq #(
  parameter int unsigned MAX_ROWS     = 256,
  parameter int unsigned MAX_NONZEROS = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [csr_el_pkg::CFG_DW-1:0]     row_count_i,
  input  logic [csr_el_pkg::CFG_DW-1:0]     column_count_i,
  csr_el_in_if.sink                         in_if,
  csr_el_out_if.source                      out_if,
  output csr_el_pkg::wr_t                   wr_o,
  output csr_el_pkg::rd_t                   rd_o,
  input  csr_el_pkg::rdata_t                rd_data_i
);
  import csr_el_pkg::*;

  localparam logic [31:0] ROW_LIM = 32'(MAX_ROWS);
  localparam logic [31:0] NZ_LIM  = 32'(MAX_NONZEROS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_END   = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic [8:0]         row_q, row_d;
  logic [7:0]         col_q, col_d;
  logic [12:0]        start_q, start_d;
  logic [12:0]        end_q, end_d;
  logic [12:0]        cur_q, cur_d;
  logic signed [31:0] res_val_q, res_val_d;
  logic               res_hit_q, res_hit_d;
  logic signed [31:0] out_val_q, out_val_d;
  logic               out_hit_q, out_hit_d;

  logic        accept;
  logic        out_range;
  logic [12:0] end_clamp;
  logic [12:0] cur_inc;

  assign in_if.ready = (state_q == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  assign out_range = (9'(in_if.query_row) >= row_count_i)
                  || (32'(in_if.query_row) >= ROW_LIM)
                  || (9'(in_if.query_col) >= column_count_i);

  assign end_clamp = (32'(rd_data_i.row_start) > NZ_LIM) ? NZ_LIM[12:0]
                                                          : rd_data_i.row_start;
  assign cur_inc   = cur_q + 13'd1;

  always_comb begin
    wr_o.we_row = accept && (in_if.req_type == REQ_WR_START)
               && (32'(in_if.slot) <= ROW_LIM);
    wr_o.we_ent = accept && (in_if.req_type == REQ_WR_ENTRY)
               && (32'(in_if.slot) < NZ_LIM);
    wr_o.slot   = in_if.slot;
    wr_o.ptr    = in_if.pointer_value;
    wr_o.col    = in_if.entry_column;
    wr_o.val    = in_if.entry_value;
  end

  always_comb begin
    rd_o.row_addr = (state_q == S_IDLE) ? 9'(in_if.query_row) : row_q + 9'd1;
    rd_o.ent_addr = (state_q == S_SCAN) ? cur_inc : start_q;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    row_d       = row_q;
    col_d       = col_q;
    start_d     = start_q;
    end_d       = end_q;
    cur_d       = cur_q;
    res_val_d   = res_val_q;
    res_hit_d   = res_hit_q;
    out_val_d   = out_val_q;
    out_hit_d   = out_hit_q;

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept && (in_if.req_type == REQ_LOOKUP)) begin
          row_d     = 9'(in_if.query_row);
          col_d     = in_if.query_col;
          res_val_d = '0;
          res_hit_d = 1'b0;
          state_d   = out_range ? S_DONE : S_START;
        end
      end
      S_START: begin
        start_d = rd_data_i.row_start;
        state_d = S_END;
      end
      S_END: begin
        end_d = end_clamp;
        cur_d = start_q;
        if (end_clamp <= start_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_data_i.ent_col == col_q) begin
          res_val_d = rd_data_i.ent_val;
          res_hit_d = 1'b1;
          state_d   = S_DONE;
        end else if (cur_inc >= end_q) begin
          state_d = S_DONE;
        end else begin
          cur_d = cur_inc;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_hit_d   = res_hit_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    col_q     <= col_d;
    start_q   <= start_d;
    end_q     <= end_d;
    cur_q     <= cur_d;
    res_val_q <= res_val_d;
    res_hit_q <= res_hit_d;
    out_val_q <= out_val_d;
    out_hit_q <= out_hit_d;
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.element_value = out_val_q;
  assign out_if.hit           = out_hit_q;

  a_beat_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result beat raised outside done state");

  a_scan_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cur_q < end_q) && (32'(end_q) <= NZ_LIM))
    else $error("scan index outside row span");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_hit_q) |-> (out_val_q == 32'sd0))
    else $error("miss result carries nonzero value");

  a_no_store_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.we_row || wr_o.we_ent) |-> (state_q == S_IDLE))
    else $error("store write while lookup in progress");

endmodule

### rtl/csr_int_element_lookup.sv
// ----------------------------------------------------------------------------
// csr_int_element_lookup
// Load beats write the stores when accepted with the slot in range. A lookup reads
// the row start, then the row end, then scans the span to a column match or its
// end; out of range goes straight to the result. Throughput: one beat at a time;
// a new beat is taken once the result is registered; scan is one entry per cycle.
// Reset clears row/column counts, sequencer state and valid; stores not cleared.
// ----------------------------------------------------------------------------
module csr_int_element_lookup #(
  parameter int unsigned MAX_ROWS     = 256,
  parameter int unsigned MAX_NONZEROS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [csr_el_pkg::CFG_DW-1:0] cfg_wdata_i,
  csr_el_in_if.sink                     in_if,
  csr_el_out_if.source                  out_if
);
  import csr_el_pkg::*;

  logic [CFG_DW-1:0] row_count_q;
  logic [CFG_DW-1:0] column_count_q;

  wr_t    wr;
  rd_t    rd;
  rdata_t rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= '0;
      column_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROW_COUNT:    row_count_q    <= cfg_wdata_i;
        CFG_COLUMN_COUNT: column_count_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  csr_el_seq #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_count_i    (row_count_q),
    .column_count_i (column_count_q),
    .in_if          (in_if),
    .out_if         (out_if),
    .wr_o           (wr),
    .rd_o           (rd),
    .rd_data_i      (rd_data)
  );

  csr_el_mem #(
    .MAX_ROWS     (MAX_ROWS),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

endmodule
